### sv/olwd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olwd_pkg
// shared types and codes of the ordered list with delete
// ----------------------------------------------------------------------------
package olwd_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIRST  = 2'd2,
    OP_NEXT   = 2'd3
  } olwd_op_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } olwd_status_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } olwd_state_t;

  localparam int unsigned IO_KEY_BITS = 16;

  typedef struct packed {
    logic shift;
    logic wr;
  } olwd_cell_ctl_t;

endpackage
`default_nettype wire

### sv/ordered_list_with_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_with_delete
// bounded ordered list of handles held in a row of shifting cells
// ----------------------------------------------------------------------------
// Append, get-first and get-next load the result register straight from the
// input beat. Delete scans for count steps, count being the number of
// entries at the time: the row of cells rotates left one place per cycle,
// the head entry is either dropped (first match) or pushed back at the tail,
// so after count steps the list is in its original order minus the deleted
// entry. A new input beat is taken while idle and the result register is
// free or being drained in the same cycle.
// ----------------------------------------------------------------------------
module ordered_list_with_delete
  import olwd_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned KEY_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             in_op,
  input  wire logic [IO_KEY_BITS-1:0] in_key,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [1:0]                  out_status,
  output logic [IO_KEY_BITS-1:0]      out_key_out
);

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  olwd_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    step_r, step_nxt;
  logic [IDX_W-1:0]    cursor_r, cursor_nxt;
  logic                cur_vld_r, cur_vld_nxt;
  logic                hit_r, hit_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [IO_KEY_BITS-1:0] out_key_r;

  logic [KEY_BITS-1:0] cell_data [CAPACITY];
  olwd_cell_ctl_t      cell_ctl [CAPACITY];

  logic                   in_fire;
  logic                   out_free;
  logic [KEY_BITS-1:0]    key_ext;
  logic                   shift_en;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [KEY_BITS-1:0]    wr_data;
  logic [IDX_W-1:0]       rd_idx;
  logic [KEY_BITS-1:0]    rd_data;
  logic [CNT_W-1:0]       next_pos;
  logic                   ld;
  olwd_status_t           ld_status;
  logic                   ld_key_sel;
  logic                   want_first;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign in_fire  = in_valid && in_ready;
  assign key_ext  = KEY_BITS'(in_key);
  assign next_pos = CNT_W'(cursor_r) + CNT_W'(1);
  assign rd_data  = cell_data[rd_idx];

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign cell_ctl[i].shift = shift_en;
    assign cell_ctl[i].wr    = wr_en && (wr_idx == IDX_W'(i));

    olwd_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .shift_in (cell_data[(i + 1) % CAPACITY]),
      .wr_data  (wr_data),
      .data_out (cell_data[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    step_nxt    = step_r;
    cursor_nxt  = cursor_r;
    cur_vld_nxt = cur_vld_r;
    hit_nxt     = hit_r;
    key_nxt     = key_r;
    shift_en    = 1'b0;
    wr_en       = 1'b0;
    wr_idx      = '0;
    wr_data     = key_ext;
    rd_idx      = '0;
    ld          = 1'b0;
    ld_status   = STS_OK;
    ld_key_sel  = 1'b0;
    want_first  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (olwd_op_t'(in_op))
            OP_APPEND: begin
              ld = 1'b1;
              if (count_r < CNT_W'(CAPACITY)) begin
                wr_en     = 1'b1;
                wr_idx    = IDX_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
                ld_status = STS_OK;
              end else begin
                ld_status = STS_FULL;
              end
            end
            OP_DELETE: begin
              cur_vld_nxt = 1'b0;
              cursor_nxt  = '0;
              hit_nxt     = 1'b0;
              key_nxt     = key_ext;
              if (count_r == '0) begin
                ld        = 1'b1;
                ld_status = STS_MISS;
              end else begin
                step_nxt  = count_r;
                state_nxt = S_SCAN;
              end
            end
            OP_FIRST: begin
              want_first = 1'b1;
            end
            OP_NEXT: begin
              if (!cur_vld_r) begin
                want_first = 1'b1;
              end else if (next_pos < count_r) begin
                ld         = 1'b1;
                cursor_nxt = IDX_W'(next_pos);
                rd_idx     = IDX_W'(next_pos);
                ld_status  = STS_OK;
                ld_key_sel = 1'b1;
              end else begin
                ld          = 1'b1;
                ld_status   = STS_MISS;
                cur_vld_nxt = 1'b0;
                cursor_nxt  = '0;
              end
            end
            default: begin
              ld        = 1'b1;
              ld_status = STS_MISS;
            end
          endcase

          if (want_first) begin
            ld         = 1'b1;
            cursor_nxt = '0;
            if (count_r == '0) begin
              ld_status   = STS_MISS;
              cur_vld_nxt = 1'b0;
            end else begin
              ld_status   = STS_OK;
              cur_vld_nxt = 1'b1;
              ld_key_sel  = 1'b1;
            end
          end
        end
      end

      S_SCAN: begin
        // pop the head, drop it on the first match, else push it at the tail
        shift_en = 1'b1;
        if ((cell_data[0] == key_r) && !hit_r) begin
          hit_nxt   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          wr_en   = 1'b1;
          wr_idx  = IDX_W'(count_r - CNT_W'(1));
          wr_data = cell_data[0];
        end
        step_nxt = step_r - CNT_W'(1);
        if (step_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          ld        = 1'b1;
          ld_status = hit_r ? STS_OK : STS_MISS;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      step_r    <= '0;
      cursor_r  <= '0;
      cur_vld_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      step_r    <= step_nxt;
      cursor_r  <= cursor_nxt;
      cur_vld_r <= cur_vld_nxt;
      hit_r     <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      out_status_r <= ld_status;
      out_key_r    <= ld_key_sel ? IO_KEY_BITS'(rd_data) : '0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_key_out = out_key_r;

endmodule
`default_nettype wire

### sv/olwd_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olwd_cell
// one list entry: takes its right neighbor on a shift, a write wins
// ----------------------------------------------------------------------------
module olwd_cell
  import olwd_pkg::*;
#(
  parameter int unsigned KEY_BITS = 16
) (
  input  wire logic                clk,
  input  wire olwd_cell_ctl_t      ctl,
  input  wire logic [KEY_BITS-1:0] shift_in,
  input  wire logic [KEY_BITS-1:0] wr_data,
  output logic      [KEY_BITS-1:0] data_out
);

  logic [KEY_BITS-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      data_r <= wr_data;
    end else if (ctl.shift) begin
      data_r <= shift_in;
    end
  end

  assign data_out = data_r;

endmodule
`default_nettype wire
